// ===== rtl/phong_pkg.sv =====
// Shared constants, types and arithmetic helpers for the Phong shading core.
// Depends on nothing; used by phong_point_light_shader_core.
package phong_pkg;

    localparam int ONE14             = 16384;
    localparam int MAX_SHININESS_DEF = 100;
    localparam int IN_W              = 208;
    localparam int OUT_W             = 48;
    localparam int SQ_STEPS          = 31;
    localparam int DV_STEPS          = 16;

    typedef enum logic [2:0] {
        CFG_LIGHT_X = 3'd0,
        CFG_LIGHT_Y = 3'd1,
        CFG_LIGHT_Z = 3'd2,
        CFG_LIGHT_R = 3'd3,
        CFG_LIGHT_G = 3'd4,
        CFG_LIGHT_B = 3'd5
    } cfg_idx_t;

    // per-item material data carried down the front of the pipe
    typedef struct packed {
        logic [2:0][15:0] n;
        logic [2:0][15:0] v;
        logic [26:0]      color;
        logic [8:0]       amb;
        logic [8:0]       dif;
        logic [8:0]       spe;
        logic [6:0]       sh;
    } mat_t;

    // what the tail needs once the vectors are done
    typedef struct packed {
        logic [14:0] diff;
        logic        pos;
        logic [8:0]  amb;
        logic [8:0]  dif;
        logic [8:0]  spe;
        logic [26:0] color;
    } shade_t;

    // round half away from zero, then drop k bits
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int unsigned k);
        logic signed [63:0] half;
        half = 64'sd1 <<< (k - 1);
        if (v >= 0)
            round_shift = (v + half) >>> k;
        else
            round_shift = -((-v + half) >>> k);
    endfunction

    function automatic logic [14:0] clamp_one(input logic signed [63:0] v);
        if (v < 0)
            clamp_one = '0;
        else if (v > 64'sd16384)
            clamp_one = 15'd16384;
        else
            clamp_one = v[14:0];
    endfunction

    function automatic logic [8:0] sat_weight(input logic [8:0] w);
        sat_weight = (w > 9'd256) ? 9'd256 : w;
    endfunction

endpackage

// ===== rtl/phong_point_light_shader_core.sv =====
// Pipeline: a result word passes the input stage, the squares, the 31-step square root,
// the 16-step divider, the vector stages, one power stage per unit of exponent and
// the colour stages before it is shown at the output.
// Throughput: one word per cycle while the skid entry is empty; a two-entry output
// buffer lets the pipe run while a result waits. Reset clears all valid bits and
// loads the light registers. Depends on phong_pkg.
module phong_point_light_shader_core
    import phong_pkg::*;
#(
    parameter int MAX_SHININESS = MAX_SHININESS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // point_xyz, normal_xyz, view_xyz, surface_color, ambient_strength,
    // diffuse_strength, specular_strength, shininess, zero fill
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // red, green, blue
    output logic [OUT_W-1:0] m_axis_tdata,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data
);

    localparam int SH_W = $clog2(MAX_SHININESS + 1);

    // configuration
    logic [15:0] light_x_reg, light_y_reg, light_z_reg;
    logic [15:0] light_r_reg, light_g_reg, light_b_reg;
    logic [2:0][15:0] lpos, lcol;

    assign cfg_ready = 1'b1;
    assign lpos = {light_z_reg, light_y_reg, light_x_reg};
    assign lcol = {light_b_reg, light_g_reg, light_r_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg <= 16'd0;
            light_y_reg <= 16'hF200;
            light_z_reg <= 16'd0;
            light_r_reg <= 16'd256;
            light_g_reg <= 16'd256;
            light_b_reg <= 16'd256;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LIGHT_X: light_x_reg <= cfg_data;
                CFG_LIGHT_Y: light_y_reg <= cfg_data;
                CFG_LIGHT_Z: light_z_reg <= cfg_data;
                CFG_LIGHT_R: light_r_reg <= cfg_data;
                CFG_LIGHT_G: light_g_reg <= cfg_data;
                CFG_LIGHT_B: light_b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline enable
    logic en;
    logic out_valid_reg, skid_valid_reg;
    logic [OUT_W-1:0] out_data_reg, skid_data_reg;

    assign en = ~skid_valid_reg;
    assign s_axis_tready = en;

    // stage registers
    logic             a_valid_reg;
    logic [2:0][16:0] a_d_reg;
    mat_t             a_mat_reg;

    logic             b_valid_reg;
    logic [2:0][31:0] b_sq_reg;
    logic [2:0][16:0] b_d_reg;
    mat_t             b_mat_reg;

    logic             rt_valid_reg [0:SQ_STEPS];
    logic [32:0]      rt_rem_reg   [0:SQ_STEPS];
    logic [30:0]      rt_root_reg  [0:SQ_STEPS];
    logic [33:0]      rt_len_reg   [0:SQ_STEPS];
    logic [2:0][16:0] rt_d_reg     [0:SQ_STEPS];
    mat_t             rt_mat_reg   [0:SQ_STEPS];

    logic             dv_valid_reg [0:DV_STEPS];
    logic [2:0][45:0] dv_num_reg   [0:DV_STEPS];
    logic [2:0][15:0] dv_q_reg     [0:DV_STEPS];
    logic [2:0]       dv_neg_reg   [0:DV_STEPS];
    logic [30:0]      dv_s_reg     [0:DV_STEPS];
    mat_t             dv_mat_reg   [0:DV_STEPS];

    logic             l_valid_reg;
    logic [2:0][15:0] l_l_reg;
    mat_t             l_mat_reg;

    logic             m1_valid_reg;
    logic [2:0][31:0] m1_np_reg;
    logic [2:0][15:0] m1_l_reg;
    mat_t             m1_mat_reg;

    logic             m2_valid_reg;
    logic [33:0]      m2_dot_reg;
    logic [2:0][15:0] m2_l_reg;
    mat_t             m2_mat_reg;

    logic             r1_valid_reg;
    logic [2:0][49:0] r1_pr_reg;
    logic [14:0]      r1_diff_reg;
    logic             r1_pos_reg;
    logic [2:0][15:0] r1_l_reg;
    mat_t             r1_mat_reg;

    logic             r2_valid_reg;
    logic [2:0][20:0] r2_r_reg;
    logic [14:0]      r2_diff_reg;
    logic             r2_pos_reg;
    mat_t             r2_mat_reg;

    logic             r3_valid_reg;
    logic [2:0][36:0] r3_vr_reg;
    logic [14:0]      r3_diff_reg;
    logic             r3_pos_reg;
    mat_t             r3_mat_reg;

    logic             r4_valid_reg;
    logic [39:0]      r4_e_reg;
    logic [14:0]      r4_diff_reg;
    logic             r4_pos_reg;
    mat_t             r4_mat_reg;

    logic             pw_valid_reg [0:MAX_SHININESS];
    logic [14:0]      pw_spec_reg  [0:MAX_SHININESS];
    logic [14:0]      pw_base_reg  [0:MAX_SHININESS];
    logic [SH_W-1:0]  pw_sh_reg    [0:MAX_SHININESS];
    shade_t           pw_shade_reg [0:MAX_SHININESS];

    logic             f_valid_reg;
    logic [23:0]      f_f_reg;
    logic [26:0]      f_color_reg;

    logic             g_valid_reg;
    logic [2:0][32:0] g_fc_reg;

    logic             h_valid_reg;
    logic [2:0][48:0] h_pr_reg;

    logic             z_valid_reg;
    logic [2:0][15:0] z_rgb_reg;

    // next values of the single stages
    logic [2:0][16:0] a_d_next;
    mat_t             a_mat_next;
    logic [2:0][31:0] b_sq_next;
    logic [33:0]      c_len_next;
    logic [2:0][45:0] p_num_next;
    logic [2:0]       p_neg_next;
    logic [2:0][15:0] l_l_next;
    logic [2:0][31:0] m1_np_next;
    logic [33:0]      m2_dot_next;
    logic [2:0][49:0] r1_pr_next;
    logic [14:0]      r1_diff_next;
    logic [2:0][20:0] r2_r_next;
    logic [2:0][36:0] r3_vr_next;
    logic [39:0]      r4_e_next;
    logic [14:0]      r5_base_next;
    logic [SH_W-1:0]  r5_sh_next;
    shade_t           r5_shade_next;
    logic [23:0]      f_f_next;
    logic [2:0][32:0] g_fc_next;
    logic [2:0][48:0] h_pr_next;
    logic [2:0][15:0] z_rgb_next;

    always_comb
    begin
        logic signed [33:0] sq;
        logic        [33:0] s0, s1, s2;
        logic        [16:0] mag;
        logic        [15:0] qc;
        logic signed [31:0] np;
        logic signed [33:0] t0, t1, t2;
        logic signed [49:0] pr;
        logic signed [63:0] rr;
        logic signed [20:0] rs;
        logic signed [36:0] vr;
        logic signed [39:0] e0, e1, e2;
        logic        [23:0] fd, fs;
        logic        [14:0] se;
        logic        [49:0] rsum;
        logic        [19:0] o;

        // A: light minus point
        for (int i = 0; i < 3; i++)
        begin
            a_d_next[i] = 17'($signed(lpos[i])) - 17'($signed(s_axis_tdata[16*i +: 16]));
        end
        a_mat_next.n     = s_axis_tdata[95:48];
        a_mat_next.v     = s_axis_tdata[143:96];
        a_mat_next.color = s_axis_tdata[170:144];
        a_mat_next.amb   = sat_weight(s_axis_tdata[179:171]);
        a_mat_next.dif   = sat_weight(s_axis_tdata[188:180]);
        a_mat_next.spe   = sat_weight(s_axis_tdata[197:189]);
        a_mat_next.sh    = s_axis_tdata[204:198];

        // B: squares
        for (int i = 0; i < 3; i++)
        begin
            sq = 34'($signed(a_d_reg[i])) * 34'($signed(a_d_reg[i]));
            b_sq_next[i] = sq[31:0];
        end

        // C: squared length
        s0 = {2'b00, b_sq_reg[0]};
        s1 = {2'b00, b_sq_reg[1]};
        s2 = {2'b00, b_sq_reg[2]};
        c_len_next = s0 + s1 + s2;

        // P: divider operands
        for (int i = 0; i < 3; i++)
        begin
            p_neg_next[i] = rt_d_reg[SQ_STEPS][i][16];
            mag = p_neg_next[i] ? (17'd0 - rt_d_reg[SQ_STEPS][i]) : rt_d_reg[SQ_STEPS][i];
            p_num_next[i] = {1'b0, mag, 28'd0} + {16'd0, rt_root_reg[SQ_STEPS][30:1]};
        end

        // L: unit light vector
        for (int i = 0; i < 3; i++)
        begin
            qc = (dv_q_reg[DV_STEPS][i] > 16'd16384) ? 16'd16384 : dv_q_reg[DV_STEPS][i];
            if (dv_s_reg[DV_STEPS] == 31'd0)
                l_l_next[i] = '0;
            else if (dv_neg_reg[DV_STEPS][i])
                l_l_next[i] = 16'd0 - qc;
            else
                l_l_next[i] = qc;
        end

        // M1, M2: N.L
        for (int i = 0; i < 3; i++)
        begin
            np = 32'($signed(l_mat_reg.n[i])) * 32'($signed(l_l_reg[i]));
            m1_np_next[i] = np;
        end
        t0 = 34'($signed(m1_np_reg[0]));
        t1 = 34'($signed(m1_np_reg[1]));
        t2 = 34'($signed(m1_np_reg[2]));
        m2_dot_next = t0 + t1 + t2;

        // R1: dot * N, diffuse factor
        for (int i = 0; i < 3; i++)
        begin
            pr = 50'($signed(m2_dot_reg)) * 50'($signed(m2_mat_reg.n[i]));
            r1_pr_next[i] = pr;
        end
        r1_diff_next = clamp_one(round_shift(64'($signed(m2_dot_reg)), 14));

        // R2: reflection vector
        for (int i = 0; i < 3; i++)
        begin
            rr = round_shift(64'($signed(r1_pr_reg[i])) <<< 1, 28);
            rs = rr[20:0];
            r2_r_next[i] = rs - 21'($signed(r1_l_reg[i]));
        end

        // R3, R4: -(V.R)
        for (int i = 0; i < 3; i++)
        begin
            vr = 37'($signed(r2_mat_reg.v[i])) * 37'($signed(r2_r_reg[i]));
            r3_vr_next[i] = vr;
        end
        e0 = 40'($signed(r3_vr_reg[0]));
        e1 = 40'($signed(r3_vr_reg[1]));
        e2 = 40'($signed(r3_vr_reg[2]));
        r4_e_next = 40'd0 - (e0 + e1 + e2);

        // R5: specular base and exponent
        r5_base_next = clamp_one(round_shift(64'($signed(r4_e_reg)), 14));
        if (int'(r4_mat_reg.sh) > MAX_SHININESS)
            r5_sh_next = SH_W'(MAX_SHININESS);
        else
            r5_sh_next = SH_W'(r4_mat_reg.sh);
        r5_shade_next.diff  = r4_diff_reg;
        r5_shade_next.pos   = r4_pos_reg;
        r5_shade_next.amb   = r4_mat_reg.amb;
        r5_shade_next.dif   = r4_mat_reg.dif;
        r5_shade_next.spe   = r4_mat_reg.spe;
        r5_shade_next.color = r4_mat_reg.color;

        // F: total weight
        se = pw_shade_reg[MAX_SHININESS].pos ? pw_spec_reg[MAX_SHININESS] : 15'd0;
        fd = 24'(pw_shade_reg[MAX_SHININESS].dif) * 24'(pw_shade_reg[MAX_SHININESS].diff);
        fs = 24'(pw_shade_reg[MAX_SHININESS].spe) * 24'(se);
        f_f_next = {1'b0, pw_shade_reg[MAX_SHININESS].amb, 14'd0} + fd + fs;

        // G, H: color and light
        for (int i = 0; i < 3; i++)
        begin
            g_fc_next[i] = 33'(f_f_reg) * 33'(f_color_reg[9*i +: 9]);
            h_pr_next[i] = 49'(g_fc_reg[i]) * 49'(lcol[i]);
        end

        // Z: round and saturate
        for (int i = 0; i < 3; i++)
        begin
            rsum = {1'b0, h_pr_reg[i]} + 50'(64'd1 << 29);
            o = rsum[49:30];
            z_rgb_next[i] = (o > 20'd65535) ? 16'hFFFF : o[15:0];
        end
    end

    // valid chain of the single stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            rt_valid_reg[0] <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
            l_valid_reg     <= 1'b0;
            m1_valid_reg    <= 1'b0;
            m2_valid_reg    <= 1'b0;
            r1_valid_reg    <= 1'b0;
            r2_valid_reg    <= 1'b0;
            r3_valid_reg    <= 1'b0;
            r4_valid_reg    <= 1'b0;
            pw_valid_reg[0] <= 1'b0;
            f_valid_reg     <= 1'b0;
            g_valid_reg     <= 1'b0;
            h_valid_reg     <= 1'b0;
            z_valid_reg     <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg     <= s_axis_tvalid;
            b_valid_reg     <= a_valid_reg;
            rt_valid_reg[0] <= b_valid_reg;
            dv_valid_reg[0] <= rt_valid_reg[SQ_STEPS];
            l_valid_reg     <= dv_valid_reg[DV_STEPS];
            m1_valid_reg    <= l_valid_reg;
            m2_valid_reg    <= m1_valid_reg;
            r1_valid_reg    <= m2_valid_reg;
            r2_valid_reg    <= r1_valid_reg;
            r3_valid_reg    <= r2_valid_reg;
            r4_valid_reg    <= r3_valid_reg;
            pw_valid_reg[0] <= r4_valid_reg;
            f_valid_reg     <= pw_valid_reg[MAX_SHININESS];
            g_valid_reg     <= f_valid_reg;
            h_valid_reg     <= g_valid_reg;
            z_valid_reg     <= h_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_d_reg   <= a_d_next;
            a_mat_reg <= a_mat_next;

            b_sq_reg  <= b_sq_next;
            b_d_reg   <= a_d_reg;
            b_mat_reg <= a_mat_reg;

            rt_len_reg[0]  <= c_len_next;
            rt_rem_reg[0]  <= '0;
            rt_root_reg[0] <= '0;
            rt_d_reg[0]    <= b_d_reg;
            rt_mat_reg[0]  <= b_mat_reg;

            dv_num_reg[0] <= p_num_next;
            dv_q_reg[0]   <= '0;
            dv_neg_reg[0] <= p_neg_next;
            dv_s_reg[0]   <= rt_root_reg[SQ_STEPS];
            dv_mat_reg[0] <= rt_mat_reg[SQ_STEPS];

            l_l_reg   <= l_l_next;
            l_mat_reg <= dv_mat_reg[DV_STEPS];

            m1_np_reg  <= m1_np_next;
            m1_l_reg   <= l_l_reg;
            m1_mat_reg <= l_mat_reg;

            m2_dot_reg <= m2_dot_next;
            m2_l_reg   <= m1_l_reg;
            m2_mat_reg <= m1_mat_reg;

            r1_pr_reg   <= r1_pr_next;
            r1_diff_reg <= r1_diff_next;
            r1_pos_reg  <= ($signed(m2_dot_reg) > 34'sd0);
            r1_l_reg    <= m2_l_reg;
            r1_mat_reg  <= m2_mat_reg;

            r2_r_reg    <= r2_r_next;
            r2_diff_reg <= r1_diff_reg;
            r2_pos_reg  <= r1_pos_reg;
            r2_mat_reg  <= r1_mat_reg;

            r3_vr_reg   <= r3_vr_next;
            r3_diff_reg <= r2_diff_reg;
            r3_pos_reg  <= r2_pos_reg;
            r3_mat_reg  <= r2_mat_reg;

            r4_e_reg    <= r4_e_next;
            r4_diff_reg <= r3_diff_reg;
            r4_pos_reg  <= r3_pos_reg;
            r4_mat_reg  <= r3_mat_reg;

            pw_spec_reg[0]  <= 15'(ONE14);
            pw_base_reg[0]  <= r5_base_next;
            pw_sh_reg[0]    <= r5_sh_next;
            pw_shade_reg[0] <= r5_shade_next;

            f_f_reg     <= f_f_next;
            f_color_reg <= pw_shade_reg[MAX_SHININESS].color;

            g_fc_reg <= g_fc_next;
            h_pr_reg <= h_pr_next;
            z_rgb_reg <= z_rgb_next;
        end
    end

    // square root, one result bit per stage
    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_sqrt
        logic [61:0] x;
        logic [34:0] cur, trial, sub;
        logic [32:0] rem_next;
        logic [30:0] root_next;

        always_comb
        begin
            x     = {rt_len_reg[j], 28'd0};
            cur   = {rt_rem_reg[j], x[61-2*j -: 2]};
            trial = {2'b00, rt_root_reg[j], 2'b01};
            sub   = cur - trial;
            if (cur >= trial)
            begin
                rem_next  = sub[32:0];
                root_next = {rt_root_reg[j][29:0], 1'b1};
            end
            else
            begin
                rem_next  = cur[32:0];
                root_next = {rt_root_reg[j][29:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rt_valid_reg[j+1] <= 1'b0;
            else if (en)
                rt_valid_reg[j+1] <= rt_valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_rem_reg[j+1]  <= rem_next;
                rt_root_reg[j+1] <= root_next;
                rt_len_reg[j+1]  <= rt_len_reg[j];
                rt_d_reg[j+1]    <= rt_d_reg[j];
                rt_mat_reg[j+1]  <= rt_mat_reg[j];
            end
        end
    end

    // restoring divider, three lanes, one quotient bit per stage
    for (genvar k = 0; k < DV_STEPS; k++)
    begin : g_div
        logic [45:0]      trial;
        logic [2:0][45:0] num_next;
        logic [2:0][15:0] q_next;

        always_comb
        begin
            trial = {15'd0, dv_s_reg[k]} << (DV_STEPS - 1 - k);
            for (int i = 0; i < 3; i++)
            begin
                if (dv_num_reg[k][i] >= trial)
                begin
                    num_next[i] = dv_num_reg[k][i] - trial;
                    q_next[i]   = {dv_q_reg[k][i][14:0], 1'b1};
                end
                else
                begin
                    num_next[i] = dv_num_reg[k][i];
                    q_next[i]   = {dv_q_reg[k][i][14:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else if (en)
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_num_reg[k+1] <= num_next;
                dv_q_reg[k+1]   <= q_next;
                dv_neg_reg[k+1] <= dv_neg_reg[k];
                dv_s_reg[k+1]   <= dv_s_reg[k];
                dv_mat_reg[k+1] <= dv_mat_reg[k];
            end
        end
    end

    // specular power, one rounded multiply per stage
    for (genvar k = 0; k < MAX_SHININESS; k++)
    begin : g_pow
        logic [29:0] prod;
        logic [14:0] spec_next;

        always_comb
        begin
            prod = 30'(pw_spec_reg[k]) * 30'(pw_base_reg[k]) + 30'd8192;
            spec_next = (pw_sh_reg[k] > SH_W'(k)) ? prod[28:14] : pw_spec_reg[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                pw_valid_reg[k+1] <= 1'b0;
            else if (en)
                pw_valid_reg[k+1] <= pw_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pw_spec_reg[k+1]  <= spec_next;
                pw_base_reg[k+1]  <= pw_base_reg[k];
                pw_sh_reg[k+1]    <= pw_sh_reg[k];
                pw_shade_reg[k+1] <= pw_shade_reg[k];
            end
        end
    end

    // output register plus skid entry
    logic push, pop;
    logic [OUT_W-1:0] z_word;

    assign z_word = {z_rgb_reg[2], z_rgb_reg[1], z_rgb_reg[0]};
    assign push = en & z_valid_reg;
    assign pop  = out_valid_reg & m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_data_reg <= z_word;
            else
                skid_data_reg <= z_word;
        end
    end

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output word");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !m_axis_tready |=> skid_valid_reg && $stable(skid_data_reg))
        else $error("skid word lost while stalled");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready && z_valid_reg))
        else $error("skid filled without a blocked push");

    a_spec_range: assert property (@(posedge clk) disable iff (!rst_n)
        pw_valid_reg[MAX_SHININESS] |-> pw_spec_reg[MAX_SHININESS] <= 15'(ONE14))
        else $error("specular factor above one");

    a_diff_range: assert property (@(posedge clk) disable iff (!rst_n)
        r1_valid_reg |-> r1_diff_reg <= 15'(ONE14))
        else $error("diffuse factor above one");
`endif

endmodule

// ===== bench/phong_checker.sv =====
// Shading checker: watches the input, output and config channels of the Phong core,
// predicts each output word and compares it. Depends on phong_pkg.
`timescale 1ns / 100ps
module phong_checker
    import phong_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [OUT_W-1:0] m_axis_tdata,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    output int               fail_count,
    output int               pending
);

    localparam int EXP_DEPTH = 1024;

    logic [15:0] lpos [3];
    logic [15:0] lcol [3];
    logic [OUT_W-1:0] exp_mem [EXP_DEPTH];
    int wr_cnt;
    int rd_cnt;

    function automatic longint sx16(input logic [15:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint rnd_shift(input longint v, input int k);
        longint half;
        half = 64'sd1 <<< (k - 1);
        if (v >= 0)
            return (v + half) >>> k;
        return -((-v + half) >>> k);
    endfunction

    function automatic longint clip_unit(input longint v);
        if (v < 0)
            return 0;
        if (v > ONE14)
            return ONE14;
        return v;
    endfunction

    function automatic longint unsigned root64(input longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned clip_weight(input logic [8:0] w);
        return (w > 9'd256) ? 256 : longint'(w);
    endfunction

    function automatic logic [OUT_W-1:0] shade(input logic [IN_W-1:0] w);
        longint p [3], n [3], v [3], d [3], l [3], r [3];
        longint unsigned len2, s, mag, q, f, prod, o, col;
        longint dotp, e, diff, base, spec;
        int sh;
        logic [OUT_W-1:0] res;
        len2 = 0;
        dotp = 0;
        e = 0;
        spec = ONE14;
        for (int i = 0; i < 3; i++)
        begin
            p[i] = sx16(w[16*i +: 16]);
            n[i] = sx16(w[48 + 16*i +: 16]);
            v[i] = sx16(w[96 + 16*i +: 16]);
            d[i] = sx16(lpos[i]) - p[i];
            len2 += longint'(d[i] * d[i]);
        end
        s = root64(len2 << 28);
        for (int i = 0; i < 3; i++)
        begin
            if (s == 0)
                l[i] = 0;
            else
            begin
                mag = (d[i] < 0) ? -d[i] : d[i];
                q = ((mag << 28) + s / 2) / s;
                if (q > ONE14)
                    q = ONE14;
                l[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
            end
            dotp += n[i] * l[i];
        end
        diff = clip_unit(rnd_shift(dotp, 14));
        if (dotp > 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                r[i] = rnd_shift(2 * dotp * n[i], 28) - l[i];
                e -= v[i] * r[i];
            end
            base = clip_unit(rnd_shift(e, 14));
            sh = w[204:198];
            if (sh > MAX_SHININESS_DEF)
                sh = MAX_SHININESS_DEF;
            repeat (sh)
                spec = (spec * base + 8192) >>> 14;
        end
        else
            spec = 0;
        f = 64'(ONE14) * clip_weight(w[179:171]) + clip_weight(w[188:180]) * diff
            + clip_weight(w[197:189]) * spec;
        for (int i = 0; i < 3; i++)
        begin
            col = w[144 + 9*i +: 9];
            prod = f * lcol[i] * col;
            o = (prod + (64'd1 << 29)) >> 30;
            res[16*i +: 16] = (o > 65535) ? 16'hFFFF : o[15:0];
        end
        return res;
    endfunction

    assign pending = wr_cnt - rd_cnt;

    always @(posedge clk or negedge rst_n)
    begin
        logic [OUT_W-1:0] exp_w;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            lpos[0] <= 16'd0;
            lpos[1] <= 16'(-3584);
            lpos[2] <= 16'd0;
            for (int i = 0; i < 3; i++)
                lcol[i] <= 16'd256;
            fail_count <= 0;
            wr_cnt <= 0;
            rd_cnt <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                exp_mem[wr_cnt % EXP_DEPTH] <= shade(s_axis_tdata);
                wr_cnt <= wr_cnt + 1;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (wr_cnt == rd_cnt)
                begin
                    $error("unexpected output word %h", m_axis_tdata);
                    errs++;
                end
                else
                begin
                    exp_w = exp_mem[rd_cnt % EXP_DEPTH];
                    rd_cnt <= rd_cnt + 1;
                    if (exp_w[15:0] != m_axis_tdata[15:0])
                    begin
                        $error("red exp %0d got %0d", exp_w[15:0], m_axis_tdata[15:0]);
                        errs++;
                    end
                    if (exp_w[31:16] != m_axis_tdata[31:16])
                    begin
                        $error("green exp %0d got %0d", exp_w[31:16], m_axis_tdata[31:16]);
                        errs++;
                    end
                    if (exp_w[47:32] != m_axis_tdata[47:32])
                    begin
                        $error("blue exp %0d got %0d", exp_w[47:32], m_axis_tdata[47:32]);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LIGHT_X: lpos[0] <= cfg_data;
                    CFG_LIGHT_Y: lpos[1] <= cfg_data;
                    CFG_LIGHT_Z: lpos[2] <= cfg_data;
                    CFG_LIGHT_R: lcol[0] <= cfg_data;
                    CFG_LIGHT_G: lcol[1] <= cfg_data;
                    CFG_LIGHT_B: lcol[2] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the Phong core bench: clock, reset, config phases, directed and random
// shading words, output stalls and the verdict. Depends on phong_pkg, phong_checker.
`timescale 1ns / 100ps
module tb_top;
    import phong_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam logic [2:0] CFG_BAD_IDX = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit calm = 1'b0;
    bit hold_out = 1'b0;

    always #5 clk = ~clk;

    phong_point_light_shader_core dut (.*);
    phong_checker chk (.*);

    // output side: random stalls, one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_out)
            m_axis_tready <= 1'b0;
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
            m_axis_tready <= 1'b1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // leaves tvalid high so words can follow back to back
    task automatic send_word(input logic [IN_W-1:0] w);
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic logic [47:0] unit_vec();
        logic signed [15:0] c [3];
        int k;
        k = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++)
            c[i] = 16'($signed($urandom_range(0, 12000)) - 6000);
        c[k] = ($urandom_range(0, 1)) ? 16'sd15000 : -16'sd15000;
        return {c[2], c[1], c[0]};
    endfunction

    function automatic logic [IN_W-1:0] make_word(input bit wild);
        logic [IN_W-1:0] w;
        w = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        if (!wild)
        begin
            w[47:0] = {16'($urandom_range(0, 4096) - 2048), 16'($urandom_range(0, 4096) - 2048),
                       16'($urandom_range(0, 4096) - 2048)};
            w[95:48] = unit_vec();
            w[143:96] = unit_vec();
            w[170:144] = {9'($urandom_range(0, 300)), 9'($urandom_range(0, 300)),
                          9'($urandom_range(0, 300))};
            w[179:171] = 9'($urandom_range(0, 260));
            w[188:180] = 9'($urandom_range(0, 260));
            w[197:189] = 9'($urandom_range(0, 260));
            w[204:198] = 7'($urandom_range(0, 110));
        end
        w[207:205] = 3'b000;
        return w;
    endfunction

    function automatic logic [IN_W-1:0] pack(input logic [47:0] p, input logic [47:0] n,
                                              input logic [47:0] v, input logic [26:0] c,
                                              input logic [8:0] a, input logic [8:0] d,
                                              input logic [8:0] s, input logic [6:0] sh);
        return {3'b000, sh, s, d, a, c, v, n, p};
    endfunction

    initial
    begin
        logic [47:0] up, down;
        up = {16'sd0, -16'sd16384, 16'sd0};
        down = {16'sd0, 16'sd16384, 16'sd0};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset light overhead
        send_word(pack('0, up, down, {9'd256, 9'd256, 9'd256}, 9'd26, 9'd256, 9'd256, 7'd32));
        send_word(pack('0, up, down, '1, 9'd511, 9'd511, 9'd511, 7'd0));
        send_word(pack('0, down, down, {9'd256, 9'd256, 9'd256}, 9'd0, 9'd256, 9'd256, 7'd5));
        send_word(pack('0, up, up, {9'd100, 9'd200, 9'd300}, 9'd10, 9'd200, 9'd256, 7'd0));
        send_word(pack('0, up, down, {9'd256, 9'd0, 9'd511}, 9'd0, 9'd0, 9'd256, 7'd127));
        send_word(pack({16'd0, 16'(-3584), 16'd0}, up, down, '1, 9'd128, 9'd256, 9'd256, 7'd3));
        send_word(pack('1, '1, '1, '1, '1, '1, '1, '1));
        send_word(pack('0, '0, '0, '0, '0, '0, '0, '0));
        send_word(pack({16'h8000, 16'h7FFF, 16'h8000}, {3{16'h7FFF}}, {3{16'h8000}},
                       '1, 9'd256, 9'd256, 9'd256, 7'd100));
        send_word(pack({3{16'h7FFF}}, {3{16'h8000}}, {3{16'h7FFF}}, '1, 9'd300, 9'd300, 9'd300,
                       7'd101));
        drain();

        write_reg(CFG_LIGHT_X, 16'h7FFF);
        write_reg(CFG_LIGHT_Y, 16'h8000);
        write_reg(CFG_LIGHT_Z, 16'h7FFF);
        write_reg(CFG_LIGHT_R, 16'hFFFF);
        write_reg(CFG_LIGHT_G, 16'h0000);
        write_reg(CFG_LIGHT_B, 16'hFFFF);
        write_reg(CFG_BAD_IDX, 16'h1234);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 10; i++)
            send_word(make_word(i[0]));

        // long hold-off on the output while input keeps coming
        hold_out = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                hold_out = 1'b0;
            end
            for (int i = 0; i < 300; i++)
                send_word(make_word(1'b0));
        join
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(CFG_LIGHT_X, (ph == 0) ? 16'h8000 : 16'($urandom_range(0, 4096) - 2048));
            write_reg(CFG_LIGHT_Y, (ph == 0) ? 16'h7FFF : 16'($urandom_range(0, 4096) - 2048));
            write_reg(CFG_LIGHT_Z, (ph == 0) ? 16'h8000 : 16'($urandom_range(0, 4096) - 2048));
            write_reg(CFG_LIGHT_R, (ph == 1) ? 16'h0 : 16'($urandom));
            write_reg(CFG_LIGHT_G, (ph == 1) ? 16'hFFFF : 16'($urandom_range(0, 1024)));
            write_reg(CFG_LIGHT_B, 16'($urandom_range(0, 600)));
            cfg_valid <= 1'b0;
            if (ph == 4)
                calm = 1'b1;
            for (int i = 0; i < 300; i++)
                send_word(make_word($urandom_range(0, 9) == 0));
            drain();
        end

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
